// ----- src/assert_macros.svh -----
// Concurrent assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define AM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition must never be seen at a rising clock edge outside reset.
`define AM_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define AM_ASSERT(lbl, clk, rst_n, prop)
`define AM_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ----- src/dpp_pkg.sv -----
// Package: constants and types of the decimal progress parser.
`timescale 1ns / 1ps
package dpp_pkg;

  localparam int unsigned DEF_BUFFER_CAPACITY = 32;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned VALUE_W = 7;

  localparam logic [BYTE_W-1:0]  DIGIT_LOW    = 8'h30;
  localparam logic [BYTE_W-1:0]  DIGIT_HIGH   = 8'h39;
  localparam logic [VALUE_W-1:0] PROGRESS_MAX = 7'd100;
  localparam logic [VALUE_W-1:0] VALUE_SAT    = 7'd101;

  // Wide enough for 101 * 10 + 9.
  localparam int unsigned ACC_W = 10;

  // Width of the packed result data (progress padded to a byte).
  localparam int unsigned OUT_DATA_W = 8;

  // One result request from the update logic to the output stage.
  typedef struct packed {
    logic                 emit;
    logic [VALUE_W-1:0]   progress;
  } dpp_result_t;

endpackage

// ----- src/decimal_progress_parser_core.sv -----
// Top level: decimal progress parser, byte stream in, progress reports out.
`timescale 1ns / 1ps
// Usage:
//   in_*  : one text byte per request in in_tdata; in_tlast marks the last
//           byte of a read chunk. Digit runs are collected across bytes and
//           across chunk boundaries; any non-digit ends a run.
//   out_* : one request per new progress percentage (1..100), sent on the
//           byte that carries in_tlast when the pending value of that chunk
//           is nonzero and differs from the previous report.
//   Path: a taken byte waits in the input register, is evaluated once the
//     output stage has space, and its report is registered there for out_tdata.
//   Throughput: 1 byte per cycle while the output stage has space; the
//     run/state update loop and the input register set that figure.
//   Stall: a two-entry output stage (register plus skid) absorbs results
//     while out_tready is low; once both entries are full the byte in the
//     input register waits and in_tready drops. in_tready does not depend
//     combinationally on out_tready.
//   Reset: rst_n low (synchronous) empties both stages and clears the run,
//     pending progress and last reported value to zero.
`include "assert_macros.svh"
module decimal_progress_parser_core #(
  parameter int unsigned BUFFER_CAPACITY = dpp_pkg::DEF_BUFFER_CAPACITY
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [dpp_pkg::BYTE_W-1:0]     in_tdata,   // [7:0] data_byte
  input  logic                           in_tlast,   // chunk_end
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [dpp_pkg::OUT_DATA_W-1:0] out_tdata   // [6:0] progress, [7] zero
);

  localparam int unsigned LEN_W = $clog2(BUFFER_CAPACITY);

  // input register
  logic                         in_vld_r;
  logic [dpp_pkg::BYTE_W-1:0]   in_byte_r;
  logic                         in_last_r;

  // parser state
  logic [LEN_W-1:0]             run_length_r, run_length_nxt;
  logic [dpp_pkg::VALUE_W-1:0]  run_value_r, run_value_nxt;
  logic [dpp_pkg::VALUE_W-1:0]  chunk_progress_r, chunk_progress_nxt;
  logic [dpp_pkg::VALUE_W-1:0]  last_reported_r, last_reported_nxt;

  dpp_pkg::dpp_result_t         result;
  logic                         space;
  logic                         consume;
  logic                         push;
  logic                         in_take;
  logic [dpp_pkg::VALUE_W-1:0]  out_data;
  logic                         out_in_range;

  // held byte is evaluated once the output stage can take a result
  assign consume   = in_vld_r && space;
  assign push      = consume && result.emit;
  assign in_tready = !in_vld_r || consume;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  dpp_run_update #(
    .BUFFER_CAPACITY (BUFFER_CAPACITY)
  ) u_update (
    .data_byte          (in_byte_r),
    .chunk_end          (in_last_r),
    .run_length         (run_length_r),
    .run_value          (run_value_r),
    .chunk_progress     (chunk_progress_r),
    .last_reported      (last_reported_r),
    .run_length_nxt     (run_length_nxt),
    .run_value_nxt      (run_value_nxt),
    .chunk_progress_nxt (chunk_progress_nxt),
    .last_reported_nxt  (last_reported_nxt),
    .result             (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_length_r     <= '0;
      run_value_r      <= '0;
      chunk_progress_r <= '0;
      last_reported_r  <= '0;
    end else if (consume) begin
      run_length_r     <= run_length_nxt;
      run_value_r      <= run_value_nxt;
      chunk_progress_r <= chunk_progress_nxt;
      last_reported_r  <= last_reported_nxt;
    end
  end

  dpp_out_skid u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (result.progress),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_data   (out_data)
  );

  assign out_tdata = {1'b0, out_data};

  assign out_in_range = (out_data != '0) && (out_data <= dpp_pkg::PROGRESS_MAX);

  // reported values stay in 1..100
  `AM_ASSERT(a_out_range, clk, rst_n, out_tvalid |-> out_in_range)
  // accumulator never passes its saturation value
  `AM_ASSERT_NEVER(a_run_sat, clk, rst_n, run_value_r > dpp_pkg::VALUE_SAT)
  // a new report always differs from the previous one
  `AM_ASSERT(a_report_new, clk, rst_n, push |-> (result.progress != last_reported_r))
  // after a report, the stored value follows it
  `AM_ASSERT(a_report_store, clk, rst_n, push |=> (last_reported_r == $past(result.progress)))

endmodule

// ----- src/dpp_run_update.sv -----
// Combinational digit-run accumulate and chunk report decision.
`timescale 1ns / 1ps
module dpp_run_update #(
  parameter int unsigned BUFFER_CAPACITY = dpp_pkg::DEF_BUFFER_CAPACITY,
  localparam int unsigned LEN_W = $clog2(BUFFER_CAPACITY)
) (
  input  logic [dpp_pkg::BYTE_W-1:0]  data_byte,
  input  logic                        chunk_end,
  input  logic [LEN_W-1:0]            run_length,
  input  logic [dpp_pkg::VALUE_W-1:0] run_value,
  input  logic [dpp_pkg::VALUE_W-1:0] chunk_progress,
  input  logic [dpp_pkg::VALUE_W-1:0] last_reported,
  output logic [LEN_W-1:0]            run_length_nxt,
  output logic [dpp_pkg::VALUE_W-1:0] run_value_nxt,
  output logic [dpp_pkg::VALUE_W-1:0] chunk_progress_nxt,
  output logic [dpp_pkg::VALUE_W-1:0] last_reported_nxt,
  output dpp_pkg::dpp_result_t        result
);

  localparam logic [LEN_W-1:0] RUN_MAX = LEN_W'(BUFFER_CAPACITY - 1);

  logic                        is_digit;
  logic [dpp_pkg::ACC_W-1:0]   acc;
  logic [dpp_pkg::VALUE_W-1:0] pending;

  assign is_digit = (data_byte >= dpp_pkg::DIGIT_LOW) && (data_byte <= dpp_pkg::DIGIT_HIGH);

  // value * 10 + digit, as two shifts and adds
  assign acc = ({3'b000, run_value} << 3) + ({3'b000, run_value} << 1)
             + dpp_pkg::ACC_W'(data_byte[3:0]);

  always_comb begin
    run_length_nxt = run_length;
    run_value_nxt  = run_value;
    pending        = chunk_progress;
    if (is_digit && (run_length < RUN_MAX)) begin
      run_value_nxt  = (acc > dpp_pkg::ACC_W'(dpp_pkg::VALUE_SAT)) ? dpp_pkg::VALUE_SAT
                                                                 : acc[dpp_pkg::VALUE_W-1:0];
      run_length_nxt = run_length + LEN_W'(1);
    end else begin
      // run ends; in-range value becomes pending progress
      if ((run_length != '0) && (run_value <= dpp_pkg::PROGRESS_MAX)) begin
        pending = run_value;
      end
      run_length_nxt = '0;
      run_value_nxt  = '0;
    end
  end

  always_comb begin
    result.emit        = 1'b0;
    result.progress    = pending;
    chunk_progress_nxt = pending;
    last_reported_nxt  = last_reported;
    if (chunk_end) begin
      if ((pending != '0) && (pending != last_reported)) begin
        result.emit       = 1'b1;
        last_reported_nxt = pending;
      end
      chunk_progress_nxt = '0;
    end
  end

endmodule

// ----- src/dpp_out_skid.sv -----
// Output register with one skid entry for the result channel.
`timescale 1ns / 1ps
module dpp_out_skid (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [dpp_pkg::VALUE_W-1:0] push_data,
  output logic                        space,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [dpp_pkg::VALUE_W-1:0] out_data
);

  logic                        main_vld_r, main_vld_nxt;
  logic                        skid_vld_r, skid_vld_nxt;
  logic [dpp_pkg::VALUE_W-1:0] main_r, main_nxt;
  logic [dpp_pkg::VALUE_W-1:0] skid_r, skid_nxt;
  logic                        pop;

  assign pop        = main_vld_r && out_tready;
  assign space      = !skid_vld_r;
  assign out_tvalid = main_vld_r;
  assign out_data   = main_r;

  always_comb begin
    main_vld_nxt = main_vld_r;
    main_nxt     = main_r;
    skid_vld_nxt = skid_vld_r;
    skid_nxt     = skid_r;
    if (pop) begin
      if (skid_vld_r) begin
        // push is held off while skid is full
        main_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end else begin
        main_vld_nxt = push;
        main_nxt     = push_data;
      end
    end else if (push) begin
      if (!main_vld_r) begin
        main_vld_nxt = 1'b1;
        main_nxt     = push_data;
      end else begin
        skid_vld_nxt = 1'b1;
        skid_nxt     = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// ----- dv/tb_decimal_progress_parser_core.sv -----
// Testbench: decimal progress parser, byte stream against a cycle-free progress predictor.
`timescale 1ns / 1ps
module tb_decimal_progress_parser_core;

  localparam int unsigned CAPACITY   = dpp_pkg::DEF_BUFFER_CAPACITY;
  localparam int unsigned RADIX      = 10;
  localparam int unsigned RAND_BYTES = 1200;
  localparam int unsigned HOLD_LEN   = 400;     // long receiver hold-off, in cycles
  localparam int unsigned DRAIN_LEN  = 8;       // settle time after the last report
  localparam int unsigned LIMIT      = 200000;  // watchdog, in cycles

  typedef struct {
    logic [dpp_pkg::BYTE_W-1:0]  b;
    bit                          last;
    bit                          typed;  // expectation written in the row
    bit                          fires;
    logic [dpp_pkg::VALUE_W-1:0] want;
  } dir_row_t;

  // Directed bytes; typed rows carry their report outcome, the rest go to the predictor.
  dir_row_t dir_rows [25] = '{
    '{"1", 1'b0, 1'b0, 1'b0, 7'd0},
    '{"0", 1'b0, 1'b0, 1'b0, 7'd0},
    '{"0", 1'b0, 1'b0, 1'b0, 7'd0},
    '{"%", 1'b1, 1'b1, 1'b1, 7'd100},  // top of range reported
    '{"1", 1'b0, 1'b0, 1'b0, 7'd0},
    '{"0", 1'b0, 1'b0, 1'b0, 7'd0},
    '{"0", 1'b0, 1'b0, 1'b0, 7'd0},
    '{"/", 1'b1, 1'b1, 1'b0, 7'd0},    // same value again: silent
    '{"0", 1'b0, 1'b0, 1'b0, 7'd0},
    '{"0", 1'b0, 1'b0, 1'b0, 7'd0},
    '{"7", 1'b0, 1'b0, 1'b0, 7'd0},
    '{"%", 1'b1, 1'b1, 1'b1, 7'd7},    // leading zeros dropped
    '{"1", 1'b0, 1'b0, 1'b0, 7'd0},
    '{"0", 1'b0, 1'b0, 1'b0, 7'd0},
    '{"1", 1'b0, 1'b0, 1'b0, 7'd0},
    '{"%", 1'b1, 1'b1, 1'b0, 7'd0},    // over range: ignored
    '{"4", 1'b0, 1'b0, 1'b0, 7'd0},
    '{"2", 1'b0, 1'b0, 1'b0, 7'd0},
    '{" ", 1'b0, 1'b0, 1'b0, 7'd0},
    '{"0", 1'b0, 1'b0, 1'b0, 7'd0},
    '{8'hFF, 1'b1, 1'b1, 1'b0, 7'd0},  // zero run clears the pending 42
    '{"5", 1'b1, 1'b1, 1'b0, 7'd0},    // run still open at chunk end
    '{8'h00, 1'b1, 1'b1, 1'b1, 7'd5},  // carried run closes in next chunk
    '{"9", 1'b0, 1'b0, 1'b0, 7'd0},
    '{":", 1'b1, 1'b1, 1'b1, 7'd9}     // byte just above the digits
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [dpp_pkg::BYTE_W-1:0] in_tdata = '0;  // [7:0] data_byte
  logic in_tlast = 1'b0;                      // chunk_end
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [dpp_pkg::OUT_DATA_W-1:0] out_tdata;  // [6:0] progress, [7] zero

  // Predictor state
  int unsigned run_len;
  int unsigned run_val;
  int unsigned chunk_prog;
  int unsigned last_rep;

  logic [dpp_pkg::VALUE_W-1:0] expected_reports [$];

  int unsigned err_count;
  int unsigned bytes_sent;
  int unsigned chunks_sent;
  int unsigned reports_seen;
  int unsigned full_runs;
  int unsigned stall_cycles;
  int unsigned cycles;
  bit          send_calm;

  decimal_progress_parser_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (rst_n && in_tvalid && !in_tready) stall_cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycles,
               expected_reports.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  // Advances the parser state by one byte; fires when a new progress is due.
  function automatic void predict_report(input logic [dpp_pkg::BYTE_W-1:0] b, input bit last,
                                         output bit fires,
                                         output logic [dpp_pkg::VALUE_W-1:0] value);
    int unsigned acc;
    bit is_digit;
    is_digit = (b >= dpp_pkg::DIGIT_LOW) && (b <= dpp_pkg::DIGIT_HIGH);
    fires = 1'b0;
    value = '0;
    if (is_digit && run_len < CAPACITY - 1) begin
      acc = run_val * RADIX + (b - dpp_pkg::DIGIT_LOW);
      run_val = (acc > dpp_pkg::VALUE_SAT) ? dpp_pkg::VALUE_SAT : acc;
      run_len++;
    end else begin
      if (is_digit) full_runs++;  // digit dropped, run was full
      if (run_len != 0 && run_val <= dpp_pkg::PROGRESS_MAX) chunk_prog = run_val;
      run_len = 0;
      run_val = 0;
    end
    if (last) begin
      if (chunk_prog != 0 && chunk_prog != last_rep) begin
        fires = 1'b1;
        value = chunk_prog[dpp_pkg::VALUE_W-1:0];
        last_rep = chunk_prog;
      end
      chunk_prog = 0;
    end
  endfunction

  // Offers one byte after a random gap, waits for the handshake, queues its report.
  task automatic feed(input logic [dpp_pkg::BYTE_W-1:0] b, input bit last, input bit typed,
                      input bit typed_fires, input logic [dpp_pkg::VALUE_W-1:0] typed_want);
    int gap;
    bit fires;
    logic [dpp_pkg::VALUE_W-1:0] value;
    gap = send_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    if (last) chunks_sent++;
    predict_report(b, last, fires, value);
    if (typed) begin
      fires = typed_fires;
      value = typed_want;
    end
    if (fires) expected_reports = {expected_reports, value};
    @(negedge clk);
  endtask

  function automatic bit coin(input int unsigned one_in);
    return $urandom_range(0, one_in - 1) == 0;
  endfunction

  function automatic logic [dpp_pkg::BYTE_W-1:0] pick_sep();
    case ($urandom_range(0, 5))
      0: return "%";
      1: return " ";
      2: return 8'h0A;
      3: return "/";
      4: return ",";
      default: begin
        // any non-digit byte
        logic [dpp_pkg::BYTE_W-1:0] b;
        do b = dpp_pkg::BYTE_W'($urandom_range(0, 255));
        while (b >= dpp_pkg::DIGIT_LOW && b <= dpp_pkg::DIGIT_HIGH);
        return b;
      end
    endcase
  endfunction

  initial begin : stimulus
    string num;
    int unsigned kind;
    int unsigned len;
    run_len = 0;
    run_val = 0;
    chunk_prog = 0;
    last_rep = 0;
    send_calm = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      feed(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].fires,
           dir_rows[i].want);

    // Mostly numbers 0..110 and a separator, plus noise, zero runs and over-long digit runs.
    while (bytes_sent < $size(dir_rows) + RAND_BYTES) begin
      if (bytes_sent % 50 == 0) send_calm = coin(4);
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        num = $sformatf("%0d", $urandom_range(0, 110));
        if (coin(5)) num = {"00", num};
        for (int k = 0; k < num.len(); k++) feed(num[k], coin(10), 1'b0, 1'b0, '0);
        feed(pick_sep(), coin(2), 1'b0, 1'b0, '0);
      end else if (kind < 80) begin
        len = $urandom_range(1, 4);
        repeat (len) feed(dpp_pkg::BYTE_W'($urandom_range(0, 255)), coin(6), 1'b0, 1'b0, '0);
      end else if (kind < 90) begin
        len = $urandom_range(CAPACITY - 4, CAPACITY + 8);
        repeat (len)
          feed(dpp_pkg::DIGIT_LOW + dpp_pkg::BYTE_W'($urandom_range(0, 9)), coin(12),
               1'b0, 1'b0, '0);
        feed(pick_sep(), coin(2), 1'b0, 1'b0, '0);
      end else begin
        repeat ($urandom_range(1, 3)) feed(dpp_pkg::DIGIT_LOW, 1'b0, 1'b0, 1'b0, '0);
        feed(pick_sep(), coin(2), 1'b0, 1'b0, '0);
      end
    end
    in_tvalid <= 1'b0;

    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_LEN) @(posedge clk);

    $display("covered %0d bytes in %0d chunks, %0d progress reports checked",
             bytes_sent, chunks_sent, reports_seen);
    $display("full digit runs: %0d, input stall cycles: %0d, mismatches: %0d",
             full_runs, stall_cycles, err_count);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Report sink: random stalls, calm stretches, and one long hold that backs up the input.
  initial begin : report_sink
    int wait_cycles;
    bit recv_calm;
    bit held;
    logic [dpp_pkg::VALUE_W-1:0] want;
    recv_calm = 1'b0;
    held = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (reports_seen % 16 == 0) recv_calm = coin(4);
      if (!held && reports_seen == 10) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end
      wait_cycles = recv_calm ? 0 : $urandom_range(0, 11);
      if (wait_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (expected_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected report %0d", out_tdata[dpp_pkg::VALUE_W-1:0]));
      end else begin
        want = expected_reports.pop_front();
        if (out_tdata[dpp_pkg::VALUE_W-1:0] !== want)
          report_mismatch($sformatf("progress %0d, want %0d",
                                    out_tdata[dpp_pkg::VALUE_W-1:0], want));
        if (out_tdata[dpp_pkg::OUT_DATA_W-1:dpp_pkg::VALUE_W] !== '0)
          report_mismatch($sformatf("pad bits %b, want zero",
                                    out_tdata[dpp_pkg::OUT_DATA_W-1:dpp_pkg::VALUE_W]));
      end
      reports_seen++;
      @(negedge clk);
    end
  end

endmodule

// ----- sim.f -----
+incdir+src
src/dpp_pkg.sv
src/dpp_run_update.sv
src/dpp_out_skid.sv
src/decimal_progress_parser_core.sv
dv/tb_decimal_progress_parser_core.sv
